>>> design/bir_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear rotate package
// Shared constants, command codes and configuration register indices.
// ----------------------------------------------------------------------------
`default_nettype none
package bir_pkg;
	localparam int DEF_MAX_ROWS  = 128;
	localparam int DEF_MAX_COLS  = 128;
	localparam int DEF_FRAC_BITS = 14;
	localparam int CNT_W   = 8;
	localparam int IDX_W   = 7;
	localparam int COEF_W  = 16;
	localparam int PIX_W   = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COS_COEFF = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_COEFF = 2'd3;
endpackage
`default_nettype wire

>>> design/bir_front.sv
// ----------------------------------------------------------------------------
// Bilinear rotate front end
// Two-stage coordinate map: products, then source point, range check and
// neighbor addresses. Emits one word per item into the queue; pixel writes
// pass through in order with the queries.
// ----------------------------------------------------------------------------
`default_nettype none
module bir_front
	import bir_pkg::*;
#(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int RA_W = $clog2(MAX_ROWS),
	parameter int CA_W = $clog2(MAX_COLS)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     cmd,
	input  wire logic [IDX_W-1:0]         row,
	input  wire logic [IDX_W-1:0]         col,
	input  wire logic [PIX_W-1:0]         pixel_in,
	input  wire logic [CNT_W-1:0]         row_count_q,
	input  wire logic [CNT_W-1:0]         col_count_q,
	input  wire logic signed [COEF_W-1:0] cos_q,
	input  wire logic signed [COEF_W-1:0] sin_q,
	output logic                          f_valid,
	input  wire logic                     f_ready,
	output logic                          f_write,
	output logic [PIX_W-1:0]              f_pix,
	output logic                          f_outside,
	output logic [RA_W-1:0]               f_r0,
	output logic [RA_W-1:0]               f_r1,
	output logic [CA_W-1:0]               f_c0,
	output logic [CA_W-1:0]               f_c1,
	output logic [FRAC_BITS-1:0]          f_fr,
	output logic [FRAC_BITS-1:0]          f_fc
);
	localparam int RN_W = $clog2(MAX_ROWS + 1);
	localparam int CN_W = $clog2(MAX_COLS + 1);
	localparam int HN_W = (RN_W > CN_W) ? RN_W : CN_W;
	localparam int D_W = ((IDX_W > HN_W) ? IDX_W : HN_W) + 1;
	localparam int P_W = D_W + COEF_W;
	localparam int S_W = P_W + 2 + FRAC_BITS;

	logic [RN_W-1:0] rows;
	logic [CN_W-1:0] cols;
	logic signed [D_W-1:0] dr, dc;
	logic signed [P_W-1:0] prc_s1, prs_s1, pcs_s1, pcc_s1;
	logic [RN_W-1:0] rows_s1;
	logic [CN_W-1:0] cols_s1;
	logic wr_s1, wok_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [IDX_W-1:0] row_s1, col_s1;
	logic v_s1, v_s2;
	logic adv1, adv2;

	always_comb begin
		if (row_count_q < 2) rows = RN_W'(2);
		else if (32'(row_count_q) > MAX_ROWS) rows = RN_W'(MAX_ROWS);
		else rows = RN_W'(row_count_q);
		if (col_count_q < 2) cols = CN_W'(2);
		else if (32'(col_count_q) > MAX_COLS) cols = CN_W'(MAX_COLS);
		else cols = CN_W'(col_count_q);
		dr = $signed(D_W'(row)) - $signed(D_W'(rows >> 1));
		dc = $signed(D_W'(col)) - $signed(D_W'(cols >> 1));
	end

	assign adv2 = !v_s2 || f_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prc_s1 <= P_W'(dr) * P_W'(cos_q);
			prs_s1 <= P_W'(dr) * P_W'(sin_q);
			pcs_s1 <= P_W'(dc) * P_W'(sin_q);
			pcc_s1 <= P_W'(dc) * P_W'(cos_q);
			rows_s1 <= rows;
			cols_s1 <= cols;
			wr_s1 <= cmd == CMD_WRITE;
			wok_s1 <= 32'(row) < MAX_ROWS && 32'(col) < MAX_COLS;
			pix_s1 <= pixel_in;
			row_s1 <= row;
			col_s1 <= col;
		end
	end

	logic signed [S_W-1:0] sr, sc;
	logic [RN_W-1:0] r0w;
	logic [CN_W-1:0] c0w;
	logic outs;
	always_comb begin
		sr = S_W'(prc_s1) - S_W'(pcs_s1)
			+ $signed(S_W'({rows_s1 >> 1, {FRAC_BITS{1'b0}}}));
		sc = S_W'(prs_s1) + S_W'(pcc_s1)
			+ $signed(S_W'({cols_s1 >> 1, {FRAC_BITS{1'b0}}}));
		outs = sr < 0 || sc < 0
			|| sr > $signed(S_W'({rows_s1 - RN_W'(1), {FRAC_BITS{1'b0}}}))
			|| sc > $signed(S_W'({cols_s1 - CN_W'(1), {FRAC_BITS{1'b0}}}));
		r0w = RN_W'(sr >>> FRAC_BITS);
		c0w = CN_W'(sc >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			f_write <= wr_s1;
			f_pix <= pix_s1;
			f_outside <= wr_s1 ? !wok_s1 : outs;
			f_r0 <= wr_s1 ? RA_W'(row_s1) : RA_W'(r0w);
			f_c0 <= wr_s1 ? CA_W'(col_s1) : CA_W'(c0w);
			f_r1 <= (r0w + RN_W'(1) > rows_s1 - RN_W'(1)) ?
				RA_W'(rows_s1 - RN_W'(1)) : RA_W'(r0w + RN_W'(1));
			f_c1 <= (c0w + CN_W'(1) > cols_s1 - CN_W'(1)) ?
				CA_W'(cols_s1 - CN_W'(1)) : CA_W'(c0w + CN_W'(1));
			f_fr <= sr[FRAC_BITS-1:0];
			f_fc <= sc[FRAC_BITS-1:0];
		end
	end

	assign f_valid = v_s2;
endmodule
`default_nettype wire

>>> design/bir_fifo.sv
// ----------------------------------------------------------------------------
// Bilinear rotate queue
// Small register queue between the front end and the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
module bir_fifo
	import bir_pkg::*;
#(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_valid,
	output logic              wr_ready,
	input  wire logic [W-1:0] wr_data,
	output logic              rd_valid,
	input  wire logic         rd_ready,
	output logic [W-1:0]      rd_data
);
	localparam int A_W = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [A_W-1:0] wp_q, rp_q;
	logic [A_W:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (A_W+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + A_W'(1);
			if (rd) rp_q <= rp_q + A_W'(1);
			cnt_q <= cnt_q + (A_W+1)'(wr) - (A_W+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

>>> design/bir_back.sv
// ----------------------------------------------------------------------------
// Bilinear rotate back end
// Four parity-banked image stores, weight products, pixel products and a
// combinational blend sum.
// ----------------------------------------------------------------------------
`default_nettype none
module bir_back
	import bir_pkg::*;
#(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int RA_W = $clog2(MAX_ROWS),
	parameter int CA_W = $clog2(MAX_COLS)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	output logic                      q_ready,
	input  wire logic                 q_write,
	input  wire logic [PIX_W-1:0]     q_pix,
	input  wire logic                 q_outside,
	input  wire logic [RA_W-1:0]      q_r0,
	input  wire logic [RA_W-1:0]      q_r1,
	input  wire logic [CA_W-1:0]      q_c0,
	input  wire logic [CA_W-1:0]      q_c1,
	input  wire logic [FRAC_BITS-1:0] q_fr,
	input  wire logic [FRAC_BITS-1:0] q_fc,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PIX_W-1:0]          pixel_out,
	output logic                      outside
);
	localparam int BR = (MAX_ROWS + 1) / 2;
	localparam int BC = (MAX_COLS + 1) / 2;
	localparam int HR_W = (RA_W > 1) ? RA_W - 1 : 1;
	localparam int HC_W = (CA_W > 1) ? CA_W - 1 : 1;
	localparam int BD = BR * BC;
	localparam int BA_W = $clog2(BD);
	localparam int W_W = FRAC_BITS + 1;
	localparam int WW_W = 2 * W_W;
	localparam int T_W = WW_W + PIX_W;
	localparam int A_W = T_W + 2;

	logic [PIX_W-1:0] bank0_q [BD];
	logic [PIX_W-1:0] bank1_q [BD];
	logic [PIX_W-1:0] bank2_q [BD];
	logic [PIX_W-1:0] bank3_q [BD];

	logic v_s1, v_s2, v_s3, adv1, adv2, adv3;
	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign q_ready = adv1;

	logic wr_en;
	logic [BA_W-1:0] wr_addr;
	logic [1:0] wr_bank;
	always_comb begin
		wr_en = q_valid && adv1 && q_write && !q_outside;
		wr_bank = {q_r0[0], q_c0[0]};
		wr_addr = BA_W'(32'(q_r0 >> 1) * BC + 32'(q_c0 >> 1));
	end

	// bank per (row parity, col parity); the four neighbors span all four
	logic [HR_W-1:0] re, ro;
	logic [HC_W-1:0] ce, co;
	logic [BA_W-1:0] a0, a1, a2, a3;
	always_comb begin
		re = q_r0[0] ? HR_W'(q_r1 >> 1) : HR_W'(q_r0 >> 1);
		ro = q_r0[0] ? HR_W'(q_r0 >> 1) : HR_W'(q_r1 >> 1);
		ce = q_c0[0] ? HC_W'(q_c1 >> 1) : HC_W'(q_c0 >> 1);
		co = q_c0[0] ? HC_W'(q_c0 >> 1) : HC_W'(q_c1 >> 1);
		a0 = BA_W'(32'(re) * BC + 32'(ce));
		a1 = BA_W'(32'(re) * BC + 32'(co));
		a2 = BA_W'(32'(ro) * BC + 32'(ce));
		a3 = BA_W'(32'(ro) * BC + 32'(co));
	end

	logic [PIX_W-1:0] p0_s1, p1_s1, p2_s1, p3_s1;
	always_ff @(posedge clk) begin
		if (wr_en && wr_bank == 2'd0) bank0_q[wr_addr] <= q_pix;
		if (wr_en && wr_bank == 2'd1) bank1_q[wr_addr] <= q_pix;
		if (wr_en && wr_bank == 2'd2) bank2_q[wr_addr] <= q_pix;
		if (wr_en && wr_bank == 2'd3) bank3_q[wr_addr] <= q_pix;
		if (adv1) begin
			p0_s1 <= bank0_q[a0];
			p1_s1 <= bank1_q[a1];
			p2_s1 <= bank2_q[a2];
			p3_s1 <= bank3_q[a3];
		end
	end

	logic rodd_s1, codd_s1, rs_s1, cs_s1, out_s1;
	logic [FRAC_BITS-1:0] fr_s1, fc_s1;
	always_ff @(posedge clk) begin
		if (adv1) begin
			rodd_s1 <= q_r0[0];
			codd_s1 <= q_c0[0];
			rs_s1 <= q_r1 == q_r0;
			cs_s1 <= q_c1 == q_c0;
			fr_s1 <= q_fr;
			fc_s1 <= q_fc;
			out_s1 <= q_outside;
		end
	end

	logic [PIX_W-1:0] n00, n01, n10, n11;
	logic [PIX_W-1:0] e00, e01, e10, e11;
	logic [W_W-1:0] fr, fc, wr1, wc1;
	always_comb begin
		e00 = rodd_s1 ? (codd_s1 ? p3_s1 : p2_s1) : (codd_s1 ? p1_s1 : p0_s1);
		e01 = rodd_s1 ? (codd_s1 ? p2_s1 : p3_s1) : (codd_s1 ? p0_s1 : p1_s1);
		e10 = rodd_s1 ? (codd_s1 ? p1_s1 : p0_s1) : (codd_s1 ? p3_s1 : p2_s1);
		e11 = rodd_s1 ? (codd_s1 ? p0_s1 : p1_s1) : (codd_s1 ? p2_s1 : p3_s1);
		n00 = e00;
		n01 = cs_s1 ? e00 : e01;
		n10 = rs_s1 ? e00 : e10;
		n11 = rs_s1 ? n01 : (cs_s1 ? e10 : e11);
		fr = W_W'(fr_s1);
		fc = W_W'(fc_s1);
		wr1 = (W_W'(1) << FRAC_BITS) - fr;
		wc1 = (W_W'(1) << FRAC_BITS) - fc;
	end

	logic [WW_W-1:0] w00_s2, w01_s2, w10_s2, w11_s2;
	logic [PIX_W-1:0] n00_s2, n01_s2, n10_s2, n11_s2;
	logic out_s2;
	always_ff @(posedge clk) begin
		if (adv2) begin
			w00_s2 <= WW_W'(wr1) * WW_W'(wc1);
			w10_s2 <= WW_W'(fr) * WW_W'(wc1);
			w01_s2 <= WW_W'(wr1) * WW_W'(fc);
			w11_s2 <= WW_W'(fr) * WW_W'(fc);
			n00_s2 <= n00;
			n01_s2 <= n01;
			n10_s2 <= n10;
			n11_s2 <= n11;
			out_s2 <= out_s1;
		end
	end

	logic [T_W-1:0] t00_s3, t01_s3, t10_s3, t11_s3;
	logic out_s3;
	always_ff @(posedge clk) begin
		if (adv3) begin
			t00_s3 <= T_W'(w00_s2) * T_W'(n00_s2);
			t01_s3 <= T_W'(w01_s2) * T_W'(n01_s2);
			t10_s3 <= T_W'(w10_s2) * T_W'(n10_s2);
			t11_s3 <= T_W'(w11_s2) * T_W'(n11_s2);
			out_s3 <= out_s2;
		end
	end

	logic [A_W-1:0] acc;
	assign acc = A_W'(t00_s3) + A_W'(t01_s3) + A_W'(t10_s3) + A_W'(t11_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= q_valid && !q_write;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;
	assign pixel_out = out_s3 ? '0 : acc[2*FRAC_BITS +: PIX_W];
	assign outside = out_s3;
endmodule
`default_nettype wire

>>> design/bilinear_image_rotate.sv
// ----------------------------------------------------------------------------
// Bilinear image rotate
// Writes source pixels into banked store; maps query points back by
// rotation about the center and blends the four neighbors.
// ----------------------------------------------------------------------------
// One word per cycle sustained for both writes and queries while the output
// is not stalled; a query result passes two coordinate stages, the queue, a
// registered read of the four parity banks, weight and product stages. The
// four neighbors come from four row/column parity banks, one read port each.
// Writes produce no result.
`default_nettype none
module bilinear_image_rotate
	import bir_pkg::*;
#(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COEF_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 cmd,
	input  wire logic [IDX_W-1:0]     row,
	input  wire logic [IDX_W-1:0]     col,
	input  wire logic [PIX_W-1:0]     pixel_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PIX_W-1:0]          pixel_out,
	output logic                      outside
);
	localparam int RA_W = $clog2(MAX_ROWS);
	localparam int CA_W = $clog2(MAX_COLS);
	localparam int QW = 2 + PIX_W + 2 * RA_W + 2 * CA_W + 2 * FRAC_BITS;

	logic [CNT_W-1:0] row_count_q, col_count_q;
	logic signed [COEF_W-1:0] cos_q, sin_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CNT_W'(128);
			col_count_q <= CNT_W'(128);
			cos_q <= COEF_W'(16384);
			sin_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data[CNT_W-1:0];
				REG_COL_COUNT: col_count_q <= cfg_data[CNT_W-1:0];
				REG_COS_COEFF: cos_q <= cfg_data;
				REG_SIN_COEFF: sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic f_valid, f_ready, f_write, f_outside;
	logic [PIX_W-1:0] f_pix;
	logic [RA_W-1:0] f_r0, f_r1;
	logic [CA_W-1:0] f_c0, f_c1;
	logic [FRAC_BITS-1:0] f_fr, f_fc;

	bir_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS),
		.RA_W(RA_W), .CA_W(CA_W)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .row, .col, .pixel_in,
		.row_count_q, .col_count_q, .cos_q, .sin_q,
		.f_valid, .f_ready, .f_write, .f_pix, .f_outside,
		.f_r0, .f_r1, .f_c0, .f_c1, .f_fr, .f_fc
	);

	logic q_valid, q_ready;
	logic [QW-1:0] q_data;
	bir_fifo #(.W(QW), .DEPTH(4)) u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data({f_write, f_pix, f_outside, f_r0, f_r1, f_c0, f_c1, f_fr, f_fc}),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	logic q_write, q_outside;
	logic [PIX_W-1:0] q_pix;
	logic [RA_W-1:0] q_r0, q_r1;
	logic [CA_W-1:0] q_c0, q_c1;
	logic [FRAC_BITS-1:0] q_fr, q_fc;
	assign {q_write, q_pix, q_outside, q_r0, q_r1, q_c0, q_c1, q_fr, q_fc} = q_data;

	bir_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS),
		.RA_W(RA_W), .CA_W(CA_W)) u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_write, .q_pix, .q_outside,
		.q_r0, .q_r1, .q_c0, .q_c1, .q_fr, .q_fc,
		.out_valid, .out_ready, .pixel_out, .outside
	);
endmodule
`default_nettype wire
